/* hw/rtl/dwpid_pkg.sv */
// shared constants, register indexes and sequencer codes for the dual wheel pid block
// no dependencies; used by the drive channel interface, the top level and the testbench
package dwpid_pkg;

  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int RATE_W      = 16;
  localparam int DRIVE_W     = 16;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = RATE_W / DIGIT_W;
  localparam int CNT_W       = $clog2(NUM_DIGITS);
  localparam int FRAC_SHIFT  = 24;
  localparam int ALIGN_SHIFT = 16;
  localparam int ADDR_W      = 5;
  localparam int APB_W       = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_DEAD_ZONE,
    REG_DRIVE_LIMIT,
    REG_TICK_FRACTION,
    REG_TICK_RATE
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_MAG,
    ST_CLAMP,
    ST_PUBLISH
  } state_t;

  typedef enum logic [2:0] {
    OP_INC,
    OP_DER,
    OP_P,
    OP_I,
    OP_D
  } op_t;

endpackage

/* hw/rtl/dwpid_if.sv */
// valid/ready channel interfaces: speed tick in, wheel drives out
// depends on dwpid_pkg for the drive width
interface dwpid_tick_if #(
  parameter int SPEED_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] left_target;
  logic signed [SPEED_WIDTH-1:0] left_measured;
  logic signed [SPEED_WIDTH-1:0] right_target;
  logic signed [SPEED_WIDTH-1:0] right_measured;
  logic                          halt;

  modport source (
    output valid, left_target, left_measured, right_target, right_measured, halt,
    input  ready
  );
  modport sink (
    input  valid, left_target, left_measured, right_target, right_measured, halt,
    output ready
  );
endinterface

interface dwpid_drive_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dwpid_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dwpid_pkg::DRIVE_W-1:0] right_drive;

  modport source (
    output valid, left_drive, right_drive,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive,
    output ready
  );
endinterface

/* hw/rtl/dual_wheel_pid_speed_control.sv */
// dual wheel pid speed control; depends on dwpid_pkg and dwpid_if
// the sequencer takes one tick at a time; a halt tick goes straight to publish, and a new
// tick waits until the last one is published; all work runs on the one shared 4-bit
// digit-serial multiplier: 10 products of 4 digit steps each, plus prep/accumulate/clamp steps
// the tick port reopens while a finished result still waits in the output register
// reset (sync, high): registers to defaults, integrals and previous errors zero, output empty
module dual_wheel_pid_speed_control #(
  parameter int SPEED_WIDTH    = 16,
  parameter int INTEGRAL_WIDTH = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dwpid_pkg::ADDR_W-1:0]   paddr,
  input  logic [dwpid_pkg::APB_W-1:0]    pwdata,
  output logic [dwpid_pkg::APB_W-1:0]    prdata,
  output logic                           pready,
  dwpid_tick_if.sink                     tick,
  dwpid_drive_if.source                  drive
);

  localparam int ERR_W  = SPEED_WIDTH + 1;
  localparam int DIFF_W = SPEED_WIDTH + 2;
  localparam int INC_W  = ERR_W + dwpid_pkg::RATE_W;
  localparam int DER_W  = DIFF_W + dwpid_pkg::RATE_W;
  localparam int MC_W   = (INTEGRAL_WIDTH > DER_W) ? INTEGRAL_WIDTH : DER_W;
  localparam int PROD_W = MC_W + dwpid_pkg::GAIN_W;
  localparam int SUM_A  = INTEGRAL_WIDTH + dwpid_pkg::GAIN_W;
  localparam int SUM_B  = DER_W + dwpid_pkg::GAIN_W + dwpid_pkg::ALIGN_SHIFT;
  localparam int SUM_W  = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 2;
  localparam int SAT_W  = ((INTEGRAL_WIDTH > INC_W) ? INTEGRAL_WIDTH : INC_W) + 1;
  localparam int QW     = SUM_W - dwpid_pkg::FRAC_SHIFT;
  localparam int PP_W   = MC_W + dwpid_pkg::DIGIT_W + 1;

  localparam logic signed [SAT_W-1:0] I_MAX =
    SAT_W'({1'b0, {(INTEGRAL_WIDTH-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] I_MIN = ~I_MAX;

  // configuration registers
  logic [dwpid_pkg::GAIN_W-1:0]  gain_p;
  logic [dwpid_pkg::GAIN_W-1:0]  gain_i;
  logic [dwpid_pkg::GAIN_W-1:0]  gain_d;
  logic [dwpid_pkg::LIMIT_W-1:0] dead_zone;
  logic [dwpid_pkg::LIMIT_W-1:0] drive_limit;
  logic [dwpid_pkg::RATE_W-1:0]  tick_fraction;
  logic [dwpid_pkg::RATE_W-1:0]  tick_rate;

  // controller state
  logic signed [INTEGRAL_WIDTH-1:0] left_integral;
  logic signed [INTEGRAL_WIDTH-1:0] right_integral;
  logic signed [ERR_W-1:0]          left_prev_error;
  logic signed [ERR_W-1:0]          right_prev_error;

  // sequencer
  dwpid_pkg::state_t              state;
  dwpid_pkg::state_t              state_next;
  dwpid_pkg::op_t                 op;
  logic                           wheel;
  logic [dwpid_pkg::CNT_W-1:0]    cnt;
  logic                           accept;
  logic                           publish;

  // datapath registers
  logic signed [SPEED_WIDTH-1:0]  tgt_l;
  logic signed [SPEED_WIDTH-1:0]  meas_l;
  logic signed [SPEED_WIDTH-1:0]  tgt_r;
  logic signed [SPEED_WIDTH-1:0]  meas_r;
  logic signed [ERR_W-1:0]        err_q;
  logic signed [DIFF_W-1:0]       diff_q;
  logic signed [DER_W-1:0]        deriv_q;
  logic signed [MC_W-1:0]         mcand;
  logic [dwpid_pkg::RATE_W-1:0]   mplier;
  logic                           msigned;
  logic signed [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]               mag;
  logic                           neg;
  logic signed [dwpid_pkg::DRIVE_W-1:0] res_l;
  logic signed [dwpid_pkg::DRIVE_W-1:0] res_r;

  // combinational values
  logic signed [SPEED_WIDTH-1:0]     cur_tgt;
  logic signed [SPEED_WIDTH-1:0]     cur_meas;
  logic signed [ERR_W-1:0]           cur_prev;
  logic signed [INTEGRAL_WIDTH-1:0]  cur_integ;
  logic signed [ERR_W-1:0]           err_calc;
  logic signed [DIFF_W-1:0]          diff_calc;
  logic [dwpid_pkg::DIGIT_W-1:0]     digit;
  logic signed [dwpid_pkg::DIGIT_W:0] sd;
  logic signed [PP_W-1:0]            pp;
  logic signed [PROD_W-1:0]          prod_step;
  logic signed [INC_W-1:0]           inc_val;
  logic signed [SAT_W-1:0]           sat_sum;
  logic signed [SAT_W-1:0]           sat_val;
  logic signed [INTEGRAL_WIDTH-1:0]  ig_new;
  logic signed [SUM_W-1:0]           acc_term;
  logic [QW-1:0]                     q_hi;
  logic [dwpid_pkg::LIMIT_W-1:0]     q_clip;
  logic [dwpid_pkg::LIMIT_W-1:0]     q_dead;
  logic [dwpid_pkg::DRIVE_W-1:0]     q_ext;
  logic [dwpid_pkg::DRIVE_W-1:0]     drive_val;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= dwpid_pkg::GAIN_W'(1);
      gain_i        <= dwpid_pkg::GAIN_W'(1);
      gain_d        <= dwpid_pkg::GAIN_W'(1);
      dead_zone     <= dwpid_pkg::LIMIT_W'(1);
      drive_limit   <= dwpid_pkg::LIMIT_W'(100);
      tick_fraction <= dwpid_pkg::RATE_W'(655);
      tick_rate     <= dwpid_pkg::RATE_W'(100);
    end else if (psel && penable && pwrite) begin
      case (dwpid_pkg::reg_idx_t'(paddr[dwpid_pkg::ADDR_W-1:2]))
        dwpid_pkg::REG_GAIN_P:        gain_p        <= pwdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::REG_GAIN_I:        gain_i        <= pwdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::REG_GAIN_D:        gain_d        <= pwdata[dwpid_pkg::GAIN_W-1:0];
        dwpid_pkg::REG_DEAD_ZONE:     dead_zone     <= pwdata[dwpid_pkg::LIMIT_W-1:0];
        dwpid_pkg::REG_DRIVE_LIMIT:   drive_limit   <= pwdata[dwpid_pkg::LIMIT_W-1:0];
        dwpid_pkg::REG_TICK_FRACTION: tick_fraction <= pwdata[dwpid_pkg::RATE_W-1:0];
        dwpid_pkg::REG_TICK_RATE:     tick_rate     <= pwdata[dwpid_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dwpid_pkg::reg_idx_t'(paddr[dwpid_pkg::ADDR_W-1:2]))
      dwpid_pkg::REG_GAIN_P:        prdata = dwpid_pkg::APB_W'(gain_p);
      dwpid_pkg::REG_GAIN_I:        prdata = dwpid_pkg::APB_W'(gain_i);
      dwpid_pkg::REG_GAIN_D:        prdata = dwpid_pkg::APB_W'(gain_d);
      dwpid_pkg::REG_DEAD_ZONE:     prdata = dwpid_pkg::APB_W'(dead_zone);
      dwpid_pkg::REG_DRIVE_LIMIT:   prdata = dwpid_pkg::APB_W'(drive_limit);
      dwpid_pkg::REG_TICK_FRACTION: prdata = dwpid_pkg::APB_W'(tick_fraction);
      dwpid_pkg::REG_TICK_RATE:     prdata = dwpid_pkg::APB_W'(tick_rate);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      dwpid_pkg::ST_IDLE: begin
        if (tick.valid) begin
          state_next = tick.halt ? dwpid_pkg::ST_PUBLISH : dwpid_pkg::ST_PREP;
        end
      end
      dwpid_pkg::ST_PREP:  state_next = dwpid_pkg::ST_MUL;
      dwpid_pkg::ST_MUL: begin
        if (cnt == dwpid_pkg::CNT_W'(dwpid_pkg::NUM_DIGITS - 1)) begin
          state_next = dwpid_pkg::ST_ACC;
        end
      end
      dwpid_pkg::ST_ACC: begin
        state_next = (op == dwpid_pkg::OP_D) ? dwpid_pkg::ST_MAG : dwpid_pkg::ST_MUL;
      end
      dwpid_pkg::ST_MAG:   state_next = dwpid_pkg::ST_CLAMP;
      dwpid_pkg::ST_CLAMP: begin
        state_next = wheel ? dwpid_pkg::ST_PUBLISH : dwpid_pkg::ST_PREP;
      end
      dwpid_pkg::ST_PUBLISH: begin
        if (!drive.valid || drive.ready) begin
          state_next = dwpid_pkg::ST_IDLE;
        end
      end
      default: state_next = dwpid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tick.ready = (state == dwpid_pkg::ST_IDLE);
    accept     = tick.valid && (state == dwpid_pkg::ST_IDLE);
    publish    = (state == dwpid_pkg::ST_PUBLISH) && (!drive.valid || drive.ready);
  end

  // ---------------------------------------------------------------- datapath logic
  assign cur_tgt   = wheel ? tgt_r : tgt_l;
  assign cur_meas  = wheel ? meas_r : meas_l;
  assign cur_prev  = wheel ? right_prev_error : left_prev_error;
  assign cur_integ = wheel ? right_integral : left_integral;
  assign err_calc  = ERR_W'(cur_tgt) - ERR_W'(cur_meas);
  assign diff_calc = DIFF_W'(err_calc) - DIFF_W'(cur_prev);

  // msb-first digit step; the top digit carries negative weight for signed gains
  assign digit     = mplier[dwpid_pkg::RATE_W-1 -: dwpid_pkg::DIGIT_W];
  assign sd        = {(cnt == '0 && msigned) ? digit[dwpid_pkg::DIGIT_W-1] : 1'b0, digit};
  assign pp        = PP_W'(mcand) * PP_W'(sd);
  assign prod_step = (prod <<< dwpid_pkg::DIGIT_W) + PROD_W'(pp);

  // saturating integral update
  assign inc_val = prod[INC_W-1:0];
  assign sat_sum = SAT_W'(cur_integ) + SAT_W'(inc_val);
  always_comb begin
    if (sat_sum > I_MAX) begin
      sat_val = I_MAX;
    end else if (sat_sum < I_MIN) begin
      sat_val = I_MIN;
    end else begin
      sat_val = sat_sum;
    end
  end
  assign ig_new = sat_val[INTEGRAL_WIDTH-1:0];

  // q.8 terms are lifted to q.24 before the sum
  always_comb begin
    case (op)
      dwpid_pkg::OP_P: acc_term = SUM_W'(prod) <<< dwpid_pkg::ALIGN_SHIFT;
      dwpid_pkg::OP_I: acc_term = SUM_W'(prod);
      dwpid_pkg::OP_D: acc_term = SUM_W'(prod) <<< dwpid_pkg::ALIGN_SHIFT;
      default:         acc_term = '0;
    endcase
  end

  // truncate toward zero, clamp, then dead zone
  always_comb begin
    q_hi      = mag[SUM_W-1:dwpid_pkg::FRAC_SHIFT];
    q_clip    = (q_hi > QW'(drive_limit)) ? drive_limit : q_hi[dwpid_pkg::LIMIT_W-1:0];
    q_dead    = (q_clip < dead_zone) ? '0 : q_clip;
    q_ext     = dwpid_pkg::DRIVE_W'(q_dead);
    drive_val = neg ? -q_ext : q_ext;
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= dwpid_pkg::ST_IDLE;
      op               <= dwpid_pkg::OP_INC;
      wheel            <= 1'b0;
      cnt              <= '0;
      drive.valid      <= 1'b0;
      left_integral    <= '0;
      right_integral   <= '0;
      left_prev_error  <= '0;
      right_prev_error <= '0;
    end else begin
      state <= state_next;
      if (publish) begin
        drive.valid <= 1'b1;
      end else if (drive.ready) begin
        drive.valid <= 1'b0;
      end
      case (state)
        dwpid_pkg::ST_IDLE: begin
          if (accept) begin
            wheel <= 1'b0;
          end
        end
        dwpid_pkg::ST_PREP: begin
          op  <= dwpid_pkg::OP_INC;
          cnt <= '0;
        end
        dwpid_pkg::ST_MUL: cnt <= cnt + dwpid_pkg::CNT_W'(1);
        dwpid_pkg::ST_ACC: begin
          cnt <= '0;
          case (op)
            dwpid_pkg::OP_INC: begin
              if (wheel) begin
                right_integral   <= ig_new;
                right_prev_error <= err_q;
              end else begin
                left_integral   <= ig_new;
                left_prev_error <= err_q;
              end
              op <= dwpid_pkg::OP_DER;
            end
            dwpid_pkg::OP_DER: op <= dwpid_pkg::OP_P;
            dwpid_pkg::OP_P:   op <= dwpid_pkg::OP_I;
            dwpid_pkg::OP_I:   op <= dwpid_pkg::OP_D;
            default: ;
          endcase
        end
        dwpid_pkg::ST_CLAMP: wheel <= 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (publish) begin
      drive.left_drive  <= res_l;
      drive.right_drive <= res_r;
    end
    case (state)
      dwpid_pkg::ST_IDLE: begin
        if (accept) begin
          tgt_l  <= tick.left_target;
          meas_l <= tick.left_measured;
          tgt_r  <= tick.right_target;
          meas_r <= tick.right_measured;
          res_l  <= '0;
          res_r  <= '0;
        end
      end
      dwpid_pkg::ST_PREP: begin
        err_q   <= err_calc;
        diff_q  <= diff_calc;
        mcand   <= MC_W'(err_calc);
        mplier  <= tick_fraction;
        msigned <= 1'b0;
        prod    <= '0;
        sum     <= '0;
      end
      dwpid_pkg::ST_MUL: begin
        prod   <= prod_step;
        mplier <= mplier << dwpid_pkg::DIGIT_W;
      end
      dwpid_pkg::ST_ACC: begin
        prod <= '0;
        case (op)
          dwpid_pkg::OP_INC: begin
            mcand   <= MC_W'(diff_q);
            mplier  <= tick_rate;
            msigned <= 1'b0;
          end
          dwpid_pkg::OP_DER: begin
            deriv_q <= prod[DER_W-1:0];
            mcand   <= MC_W'(err_q);
            mplier  <= gain_p;
            msigned <= 1'b1;
          end
          dwpid_pkg::OP_P: begin
            sum     <= sum + acc_term;
            mcand   <= MC_W'(cur_integ);
            mplier  <= gain_i;
            msigned <= 1'b1;
          end
          dwpid_pkg::OP_I: begin
            sum     <= sum + acc_term;
            mcand   <= MC_W'(deriv_q);
            mplier  <= gain_d;
            msigned <= 1'b1;
          end
          dwpid_pkg::OP_D: sum <= sum + acc_term;
          default: ;
        endcase
      end
      dwpid_pkg::ST_MAG: begin
        neg <= sum[SUM_W-1];
        mag <= sum[SUM_W-1] ? -sum : sum;
      end
      dwpid_pkg::ST_CLAMP: begin
        if (wheel) begin
          res_r <= drive_val;
        end else begin
          res_l <= drive_val;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- assertions
  a_halt_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && tick.halt) |=> ($stable(left_integral) && $stable(right_integral) &&
                               $stable(left_prev_error) && $stable(right_prev_error)))
    else $error("halt item changed controller state");

  a_run_starts_left: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick.halt) |=> (state == dwpid_pkg::ST_PREP && !wheel))
    else $error("run item did not start on the left wheel");

  a_mag_after_all_terms: assert property (@(posedge clk) disable iff (rst)
    (state == dwpid_pkg::ST_MAG) |-> (op == dwpid_pkg::OP_D))
    else $error("drive formed before all three terms were summed");

  a_publish_fills_output: assert property (@(posedge clk) disable iff (rst)
    (state == dwpid_pkg::ST_PUBLISH && drive.ready) |=> drive.valid)
    else $error("finished result not placed in output register");

endmodule

/* tb/testbench.sv */
// self-checking testbench for dual_wheel_pid_speed_control: directed ticks, then random
// ticks under several register settings; a scoreboard class predicts both wheel drives
// depends on dwpid_pkg, dwpid_if and the rtl top level
module testbench;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam longint INTEG_MAX = (64'sd1 <<< 47) - 1;
  localparam longint INTEG_MIN = -(64'sd1 <<< 47);
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 90;

  typedef struct {
    logic signed [15:0] left_target;
    logic signed [15:0] left_measured;
    logic signed [15:0] right_target;
    logic signed [15:0] right_measured;
    logic               halt;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } drive_pair_t;

  class drive_scoreboard;
    logic signed [15:0] gain_p, gain_i, gain_d;
    logic [14:0] dead_zone, drive_limit;
    logic [15:0] tick_fraction, tick_rate;
    logic signed [63:0] integral [2];
    logic signed [16:0] last_error [2];
    drive_pair_t expected_drives [$];
    int failures;

    function new();
      gain_p = 1;
      gain_i = 1;
      gain_d = 1;
      dead_zone = 1;
      drive_limit = 100;
      tick_fraction = 655;
      tick_rate = 100;
      for (int w = 0; w < 2; w++) begin
        integral[w] = 0;
        last_error[w] = 0;
      end
      failures = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        dwpid_pkg::REG_GAIN_P:        gain_p = val[15:0];
        dwpid_pkg::REG_GAIN_I:        gain_i = val[15:0];
        dwpid_pkg::REG_GAIN_D:        gain_d = val[15:0];
        dwpid_pkg::REG_DEAD_ZONE:     dead_zone = val[14:0];
        dwpid_pkg::REG_DRIVE_LIMIT:   drive_limit = val[14:0];
        dwpid_pkg::REG_TICK_FRACTION: tick_fraction = val[15:0];
        dwpid_pkg::REG_TICK_RATE:     tick_rate = val[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] wheel_drive(int w, logic signed [15:0] tgt,
                                             logic signed [15:0] meas);
      logic signed [16:0]  err;
      logic signed [63:0]  inc, slope, acc;
      logic signed [127:0] term_p, term_i, term_d, total;
      logic [127:0]        mag;
      logic signed [15:0]  drv;
      logic                neg;
      err = tgt - meas;
      inc = err * $signed({1'b0, tick_fraction});
      // derivative uses the error of the previous tick
      slope = (err - last_error[w]) * $signed({1'b0, tick_rate});
      acc = integral[w] + inc;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      else if (acc < INTEG_MIN) acc = INTEG_MIN;
      integral[w] = acc;
      last_error[w] = err;
      // all terms aligned to 24 fraction bits
      term_p = gain_p * err;
      term_p = term_p <<< 16;
      term_i = gain_i * acc;
      term_d = gain_d * slope;
      term_d = term_d <<< 16;
      total = term_p + term_i + term_d;
      neg = total[127];
      mag = neg ? -total : total;
      mag = mag >> 24;
      if (mag > drive_limit) mag = drive_limit;
      if (mag < dead_zone) mag = 0;
      drv = mag[15:0];
      if (neg) drv = -drv;
      return drv;
    endfunction

    function void note_tick(tick_t t);
      drive_pair_t d;
      d = '0;
      if (!t.halt) begin
        d.left = wheel_drive(0, t.left_target, t.left_measured);
        d.right = wheel_drive(1, t.right_target, t.right_measured);
      end
      expected_drives.push_back(d);
    endfunction

    function void check_drive(logic signed [15:0] left, logic signed [15:0] right);
      drive_pair_t d;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected drive item: left %0d right %0d", left, right);
        return;
      end
      d = expected_drives.pop_front();
      if (left !== d.left || right !== d.right) begin
        failures++;
        if (failures <= 10)
          $display("drive mismatch: expected left %0d right %0d, got left %0d right %0d",
                   d.left, d.right, left, right);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [dwpid_pkg::ADDR_W-1:0] paddr;
  logic [dwpid_pkg::APB_W-1:0] pwdata, prdata;
  bit steady = 0;
  bit hold_output = 0;
  int stuck_cycles = 0;
  drive_scoreboard sb = new();

  dwpid_tick_if #(.SPEED_WIDTH(16)) tick();
  dwpid_drive_if drive();

  dual_wheel_pid_speed_control dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tick(tick),
    .drive(drive)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    tick_t seen;
    bit took;
    took = 0;
    if (!rst) begin
      if (drive.valid && drive.ready) begin
        sb.check_drive(drive.left_drive, drive.right_drive);
        took = 1;
      end
      if (tick.valid && tick.ready) begin
        seen.left_target = tick.left_target;
        seen.left_measured = tick.left_measured;
        seen.right_target = tick.right_target;
        seen.right_measured = tick.right_measured;
        seen.halt = tick.halt;
        sb.note_tick(seen);
        took = 1;
      end
    end
    stuck_cycles = took ? 0 : stuck_cycles + 1;
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("dual_wheel_pid_speed_control verification failed");
    $finish;
  end

  initial begin : receiver
    drive.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        // long hold so the block backs up and stalls its tick port
        drive.ready = 0;
        hold_output = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      drive.ready = steady || ($urandom_range(99) >= 11);
    end
  end

  function automatic tick_t make_tick(logic signed [15:0] lt, logic signed [15:0] lm,
                                      logic signed [15:0] rt, logic signed [15:0] rm,
                                      logic h);
    tick_t t;
    t.left_target = lt;
    t.left_measured = lm;
    t.right_target = rt;
    t.right_measured = rm;
    t.halt = h;
    return t;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic send_tick(input tick_t t);
    tick.left_target = t.left_target;
    tick.left_measured = t.left_measured;
    tick.right_target = t.right_target;
    tick.right_measured = t.right_measured;
    tick.halt = t.halt;
    tick.valid = 1;
    do @(posedge clk); while (!tick.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    tick.valid = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] gp, input logic [15:0] gi,
                           input logic [15:0] gd, input logic [14:0] dz,
                           input logic [14:0] lim, input logic [15:0] tf,
                           input logic [15:0] tr);
    write_reg(dwpid_pkg::REG_GAIN_P, {16'h0, gp});
    write_reg(dwpid_pkg::REG_GAIN_I, {16'h0, gi});
    write_reg(dwpid_pkg::REG_GAIN_D, {16'h0, gd});
    write_reg(dwpid_pkg::REG_DEAD_ZONE, {17'h0, dz});
    write_reg(dwpid_pkg::REG_DRIVE_LIMIT, {17'h0, lim});
    write_reg(dwpid_pkg::REG_TICK_FRACTION, {16'h0, tf});
    write_reg(dwpid_pkg::REG_TICK_RATE, {16'h0, tr});
  endtask

  function automatic logic [15:0] pick_gain();
    if ($urandom_range(99) < 70) return 16'($urandom_range(0, 256) - 128);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic configure(input int phase);
    logic [14:0] dz, lim;
    logic [15:0] tf, tr;
    if (phase == NUM_PHASES - 2) begin
      write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0, 15'h7FFF, 16'hFFFF, 16'hFFFF);
    end else if (phase == NUM_PHASES - 1) begin
      // only clamped magnitudes get past the dead zone here
      write_all(16'h8000, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 16'd1, 16'd1);
    end else begin
      lim = ($urandom_range(99) < 20) ? 15'($urandom_range(0, 300))
                                      : 15'($urandom_range(0, 32767));
      dz = ($urandom_range(99) < 80) ? 15'($urandom_range(0, 64))
                                     : 15'($urandom_range(0, 32767));
      tf = ($urandom_range(1) != 0) ? 16'($urandom_range(1, 1024))
                                    : 16'($urandom_range(1, 65535));
      tr = ($urandom_range(1) != 0) ? 16'($urandom_range(1, 256))
                                    : 16'($urandom_range(1, 65535));
      write_all(pick_gain(), pick_gain(), pick_gain(), dz, lim, tf, tr);
    end
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    int r;
    r = $urandom_range(99);
    t.left_measured = 16'($urandom_range(0, 65535));
    t.right_measured = 16'($urandom_range(0, 65535));
    t.halt = (r < 10);
    if (r < 35) begin
      t.left_target = 16'($urandom_range(0, 65535));
      t.right_target = 16'($urandom_range(0, 65535));
    end else begin
      // target close to measured keeps the integral in a useful range
      t.left_target = t.left_measured + 16'($urandom_range(0, 1024) - 512);
      t.right_target = t.right_measured + 16'($urandom_range(0, 1024) - 512);
    end
    return t;
  endfunction

  task automatic run_random(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      if (!steady && $urandom_range(99) < 11) begin
        tick.valid = 0;
        repeat ($urandom_range(1, 64)) @(negedge clk);
      end
      send_tick(random_tick());
    end
  endtask

  initial begin : stimulus
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    tick.valid = 0;
    tick.left_target = 0;
    tick.left_measured = 0;
    tick.right_target = 0;
    tick.right_measured = 0;
    tick.halt = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings, field extremes
    send_tick(make_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
    send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
    send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
    send_tick(make_tick(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1));
    send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_tick(make_tick(16'sd256, 16'sd0, 16'sd0, 16'sd256, 1'b0));
    send_tick(make_tick(-16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0));
    send_tick(make_tick(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1'b0));
    drain();

    // integral frozen and derivative off
    write_reg(dwpid_pkg::REG_TICK_FRACTION, 32'd0);
    write_reg(dwpid_pkg::REG_TICK_RATE, 32'd0);
    send_tick(make_tick(16'sd512, 16'sd0, -16'sd512, 16'sd0, 1'b0));
    send_tick(make_tick(16'sd512, 16'sd0, -16'sd512, 16'sd0, 1'b0));
    send_tick(make_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1));
    drain();
    write_reg(dwpid_pkg::REG_TICK_FRACTION, 32'd655);
    write_reg(dwpid_pkg::REG_TICK_RATE, 32'd100);

    // zero limit
    write_reg(dwpid_pkg::REG_DRIVE_LIMIT, 32'd0);
    send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
    send_tick(make_tick(16'sd1000, 16'sd0, 16'sd0, 16'sd1000, 1'b0));
    drain();

    // dead zone above the limit
    write_reg(dwpid_pkg::REG_DRIVE_LIMIT, 32'd100);
    write_reg(dwpid_pkg::REG_DEAD_ZONE, 32'd200);
    send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
    send_tick(make_tick(16'sd300, 16'sd0, 16'sd0, 16'sd300, 1'b0));
    drain();

    // a write past the last register must change nothing
    write_reg(dwpid_pkg::REG_DEAD_ZONE, 32'd1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_tick(make_tick(16'sd300, 16'sd0, 16'sd0, 16'sd300, 1'b0));
    send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(p);
      steady = (p == 1);
      if (p == 2) hold_output = 1;
      run_random(PHASE_ITEMS, p == 3);
      drain();
    end
    steady = 0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("dual_wheel_pid_speed_control verification clean");
    else
      $display("dual_wheel_pid_speed_control verification failed");
    $finish;
  end
endmodule
